// File: rtl/core/rme_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_pkg
// Types, constants and helper functions shared by the rotation-matrix to
// Euler-angle pipeline.
// ----------------------------------------------------------------------------
package rme_pkg;

    localparam int XY_W      = 32;
    localparam int Z_W       = 34;
    localparam int REM_W     = 58;
    localparam int SQRT_BITS = 29;
    localparam int TABLE_LEN = 24;

    localparam logic [1:0] LOCK_NONE = 2'd0;
    localparam logic [1:0] LOCK_NEG  = 2'd1;
    localparam logic [1:0] LOCK_POS  = 2'd2;

    localparam logic signed [Z_W-1:0] PI_Q30      = 34'sd3373259427;
    localparam logic signed [15:0]    HALF_PI_Q13 = 16'sd12868;
    localparam logic signed [15:0]    ANGLE_MAX   = 16'sd25736;
    localparam logic signed [15:0]    ONE_Q14     = 16'sd16384;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
    } t_cordic;

    typedef struct packed {
        logic [1:0]       code;
        logic             zero_b;
        logic             zero_c;
        logic [REM_W-1:0] rem;
        t_cordic          a;
        t_cordic          b;
        t_cordic          c;
    } t_item;

    function automatic logic signed [Z_W-1:0] atan_q30(input logic [4:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd843314857;
            5'd1:    v = 34'sd497837829;
            5'd2:    v = 34'sd263043837;
            5'd3:    v = 34'sd133525159;
            5'd4:    v = 34'sd67021687;
            5'd5:    v = 34'sd33543516;
            5'd6:    v = 34'sd16775851;
            5'd7:    v = 34'sd8388437;
            5'd8:    v = 34'sd4194283;
            5'd9:    v = 34'sd2097149;
            5'd10:   v = 34'sd1048576;
            5'd11:   v = 34'sd524288;
            5'd12:   v = 34'sd262144;
            5'd13:   v = 34'sd131072;
            5'd14:   v = 34'sd65536;
            5'd15:   v = 34'sd32768;
            5'd16:   v = 34'sd16384;
            5'd17:   v = 34'sd8192;
            5'd18:   v = 34'sd4096;
            5'd19:   v = 34'sd2048;
            5'd20:   v = 34'sd1024;
            5'd21:   v = 34'sd512;
            5'd22:   v = 34'sd256;
            5'd23:   v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q2.14 (17 bit) to CORDIC operand scaled by 2^14
    function automatic logic signed [XY_W-1:0] widen(input logic signed [16:0] v);
        return {v[16], v, 14'b0};
    endfunction

    // fold x < 0 into the right half-plane
    function automatic t_cordic prerot(input logic signed [XY_W-1:0] y,
                                       input logic signed [XY_W-1:0] x);
        t_cordic r;
        r.x = x;
        r.y = y;
        r.z = '0;
        if (x < 0) begin
            r.x = -x;
            r.y = -y;
            r.z = (y >= 0) ? PI_Q30 : -PI_Q30;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q13(input logic signed [Z_W-1:0] z);
        logic signed [Z_W:0] t;
        logic signed [15:0]  r;
        t = ($signed({z[Z_W-1], z}) + 35'sd65536) >>> 17;
        if (t > 35'(ANGLE_MAX)) begin
            r = ANGLE_MAX;
        end else if (t < -35'(ANGLE_MAX)) begin
            r = -ANGLE_MAX;
        end else begin
            r = t[15:0];
        end
        return r;
    endfunction

endpackage

// File: rtl/core/rme_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_front
// Input cell: lock detection, operand selection, pre-rotation and the
// square-root radicand for the asin path.
// ----------------------------------------------------------------------------
module rme_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [14:0]         i_tol,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [111:0]        i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output rme_pkg::t_item      o_item
);

    logic signed [15:0] r00, r01, r02, r10, r12, r20, r22;
    logic signed [17:0] dm, dp;
    logic               lock_neg, lock_pos;
    logic signed [15:0] s;
    logic signed [31:0] s2;
    logic [28:0]        m;
    logic signed [16:0] cy, cx;
    rme_pkg::t_item     n_item;
    rme_pkg::t_item     r_item;
    logic               r_valid;

    assign r00 = i_data[15:0];
    assign r01 = i_data[31:16];
    assign r02 = i_data[47:32];
    assign r10 = i_data[63:48];
    assign r12 = i_data[79:64];
    assign r20 = i_data[95:80];
    assign r22 = i_data[111:96];

    always_comb begin
        dm = 18'(r02) + 18'sd16384;
        dp = 18'(r02) - 18'sd16384;
        if (dm < 0) begin
            dm = -dm;
        end
        if (dp < 0) begin
            dp = -dp;
        end
        lock_neg = $signed({3'b0, i_tol}) > dm;
        lock_pos = $signed({3'b0, i_tol}) > dp;

        if (r02 > rme_pkg::ONE_Q14) begin
            s = rme_pkg::ONE_Q14;
        end else if (r02 < -rme_pkg::ONE_Q14) begin
            s = -rme_pkg::ONE_Q14;
        end else begin
            s = r02;
        end
        s2 = s * s;
        m  = 29'd268435456 - s2[28:0];

        if (lock_neg) begin
            n_item.code = rme_pkg::LOCK_NEG;
            cy = 17'(r10);
            cx = 17'(r20);
        end else if (lock_pos) begin
            n_item.code = rme_pkg::LOCK_POS;
            cy = -17'(r10);
            cx = -17'(r20);
        end else begin
            n_item.code = rme_pkg::LOCK_NONE;
            cy = 17'(r01);
            cx = 17'(r00);
        end

        n_item.rem    = {1'b0, m, 28'b0};
        n_item.a.x    = '0;
        n_item.a.y    = rme_pkg::widen(17'(s));
        n_item.a.z    = '0;
        n_item.b      = rme_pkg::prerot(rme_pkg::widen(17'(r12)), rme_pkg::widen(17'(r22)));
        n_item.c      = rme_pkg::prerot(rme_pkg::widen(cy), rme_pkg::widen(cx));
        n_item.zero_b = (r12 == 0) && (r22 == 0);
        n_item.zero_c = (cy == 0) && (cx == 0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/rme_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_sqrt_cell
// One bit of the restoring square root; the root builds up in a.x.
// ----------------------------------------------------------------------------
module rme_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rme_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output rme_pkg::t_item o_item
);

    logic [rme_pkg::REM_W-1:0] trial;
    logic [rme_pkg::SQRT_BITS-1:0] root;
    rme_pkg::t_item n_item;
    rme_pkg::t_item r_item;
    logic           r_valid;

    always_comb begin
        n_item = i_item;
        root   = i_item.a.x[rme_pkg::SQRT_BITS-1:0];
        trial  = ({{(rme_pkg::REM_W-rme_pkg::SQRT_BITS){1'b0}}, root} << (BIT + 1))
               + ({{(rme_pkg::REM_W-1){1'b0}}, 1'b1} << (2 * BIT));
        if (i_item.rem >= trial) begin
            n_item.rem = i_item.rem - trial;
            root[BIT]  = 1'b1;
        end
        n_item.a.x = {{(rme_pkg::XY_W-rme_pkg::SQRT_BITS){1'b0}}, root};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/rme_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_cordic_cell
// One vectoring CORDIC iteration, applied to all three angle channels.
// ----------------------------------------------------------------------------
module rme_cordic_cell #(
    parameter int STAGE = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rme_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output rme_pkg::t_item o_item
);

    rme_pkg::t_item n_item;
    rme_pkg::t_item r_item;
    logic           r_valid;

    function automatic rme_pkg::t_cordic rot(input rme_pkg::t_cordic v);
        rme_pkg::t_cordic      r;
        logic signed [rme_pkg::XY_W-1:0] xs;
        logic signed [rme_pkg::XY_W-1:0] ys;
        xs = v.x >>> STAGE;
        ys = v.y >>> STAGE;
        if (v.y > 0) begin
            r.x = v.x + ys;
            r.y = v.y - xs;
            r.z = v.z + rme_pkg::atan_q30(5'(STAGE));
        end else begin
            r.x = v.x - ys;
            r.y = v.y + xs;
            r.z = v.z - rme_pkg::atan_q30(5'(STAGE));
        end
        return r;
    endfunction

    always_comb begin
        n_item   = i_item;
        n_item.a = rot(i_item.a);
        n_item.b = rot(i_item.b);
        n_item.c = rot(i_item.c);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/core/rme_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_back
// Output cell: rounding to Q3.13, saturation and lock-case substitution.
// ----------------------------------------------------------------------------
module rme_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  rme_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [47:0]    o_data,
    output logic [1:0]     o_code
);

    logic signed [15:0] ax, ay, az;
    logic [47:0]        r_data;
    logic [1:0]         r_code;
    logic               r_valid;

    always_comb begin
        az = i_item.zero_c ? 16'sd0 : rme_pkg::to_q13(i_item.c.z);
        case (i_item.code)
            rme_pkg::LOCK_NEG: begin
                ax = '0;
                ay = rme_pkg::HALF_PI_Q13;
            end
            rme_pkg::LOCK_POS: begin
                ax = '0;
                ay = -rme_pkg::HALF_PI_Q13;
            end
            default: begin
                ax = rme_pkg::to_q13(-i_item.a.z);
                ay = i_item.zero_b ? 16'sd0 : rme_pkg::to_q13(i_item.b.z);
            end
        endcase
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_data <= {az, ay, ax};
            r_code <= i_item.code;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_code  = r_code;

endmodule

// File: rtl/core/rotation_matrix_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotation_matrix_to_euler_angles_unit
// Seven Q1.14 rotation-matrix elements in, three Q3.13 Euler angles and a
// gimbal-lock code out.
// ----------------------------------------------------------------------------
// One matrix is taken per clock while s_axis_tready is high. The path is:
// one input cell, a chain of 29 square-root cells (one root bit each, for the
// cosine feeding asin), CORDIC_STAGES vectoring cells that rotate all three
// channels together, and one rounding cell. Every cell has its own valid
// bit, so bubbles collapse and the input keeps flowing while a result waits.
// ----------------------------------------------------------------------------
module rotation_matrix_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [14:0]  i_cfg_wr_data,   // lock_tolerance
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,    // r00, r01, r02, r10, r12, r20, r22
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [47:0]  m_axis_tdata,    // angle_x, angle_y, angle_z
    output logic [1:0]   m_axis_tuser     // lock_case
);

    localparam int NSQ = rme_pkg::SQRT_BITS;

    logic [14:0]          r_lock_tolerance;
    rme_pkg::t_item       w_sq [0:NSQ];
    logic [NSQ:0]         w_sq_valid;
    logic [NSQ:0]         w_sq_ready;
    rme_pkg::t_item       w_cd [0:CORDIC_STAGES];
    logic [CORDIC_STAGES:0] w_cd_valid;
    logic [CORDIC_STAGES:0] w_cd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_tolerance <= 15'd16;
        end else if (i_cfg_wr_en) begin
            r_lock_tolerance <= i_cfg_wr_data;
        end
    end

    rme_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tol   (r_lock_tolerance),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_valid (w_sq_valid[0]),
        .i_ready (w_sq_ready[0]),
        .o_item  (w_sq[0])
    );

    for (genvar g = 0; g < NSQ; g++) begin : g_sqrt
        rme_sqrt_cell #(
            .BIT (NSQ - 1 - g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_valid[g]),
            .o_ready (w_sq_ready[g]),
            .i_item  (w_sq[g]),
            .o_valid (w_sq_valid[g+1]),
            .i_ready (w_sq_ready[g+1]),
            .o_item  (w_sq[g+1])
        );
    end

    assign w_cd[0]       = w_sq[NSQ];
    assign w_cd_valid[0] = w_sq_valid[NSQ];
    assign w_sq_ready[NSQ] = w_cd_ready[0];

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        rme_cordic_cell #(
            .STAGE (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_cd_valid[k]),
            .o_ready (w_cd_ready[k]),
            .i_item  (w_cd[k]),
            .o_valid (w_cd_valid[k+1]),
            .i_ready (w_cd_ready[k+1]),
            .o_item  (w_cd[k+1])
        );
    end

    rme_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cd_valid[CORDIC_STAGES]),
        .o_ready (w_cd_ready[CORDIC_STAGES]),
        .i_item  (w_cd[CORDIC_STAGES]),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (m_axis_tdata),
        .o_code  (m_axis_tuser)
    );

endmodule

// File: rtl/core/rme_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rme_checker
// Port-level checks on the output stream of the Euler-angle unit.
// ----------------------------------------------------------------------------
module rme_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("beat dropped under back-pressure");

    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("valid beat straight after reset");

    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("illegal lock code");

    a_lock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != rme_pkg::LOCK_NONE |->
        m_axis_tdata[15:0] == 16'd0 &&
        ($signed(m_axis_tdata[31:16]) == rme_pkg::HALF_PI_Q13 ||
         $signed(m_axis_tdata[31:16]) == -rme_pkg::HALF_PI_Q13))
        else $error("lock beat with wrong x or y");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
        $signed(m_axis_tdata[47:32]) <= rme_pkg::ANGLE_MAX &&
        $signed(m_axis_tdata[47:32]) >= -rme_pkg::ANGLE_MAX)
        else $error("angle_z out of range");

endmodule

bind rotation_matrix_to_euler_angles_unit rme_checker u_rme_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: verif/tb_rotation_matrix_to_euler_angles_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_euler_angles_unit
// Streams rotation matrices through the Euler-angle unit and checks every
// output beat against a fixed-point CORDIC predictor, across several lock
// tolerance settings, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_euler_angles_unit;

    localparam int STAGES = 16;
    localparam int LATENCY = 31 + STAGES;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [15:0] r22, r20, r12, r10, r02, r01, r00;
    } t_matrix;

    typedef struct packed {
        logic [1:0]         code;
        logic signed [15:0] az, ay, ax;
    } t_angles;

    typedef struct {
        t_matrix m;
        bit      has_exp;
        t_angles exp;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [14:0]  i_cfg_wr_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [47:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    rotation_matrix_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    longint  tol;
    t_angles angles_due[$];
    int      errors;
    int      beats_in;
    int      beats_out;
    int      lock_seen[3];
    longint  cycles;

    localparam longint ATAN_TAB[24] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    localparam longint PI30 = 64'sd3373259427;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint vec_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            z = (y >= 0) ? PI30 : -PI30;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    function automatic longint round_q13(longint z);
        longint r;
        r = (z + 65536) >>> 17;
        if (r > 25736) r = 25736;
        if (r < -25736) r = -25736;
        return r;
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= v) r |= (64'd1 << b);
        end
        return r;
    endfunction

    function automatic t_angles euler_of(t_matrix m);
        t_angles a;
        longint  s;
        longint  dm;
        longint  dp;
        dm = longint'(m.r02) + 16384;
        dp = longint'(m.r02) - 16384;
        if (dm < 0) dm = -dm;
        if (dp < 0) dp = -dp;
        if (tol > dm) begin
            a.code = rme_pkg::LOCK_NEG;
            a.ax = '0;
            a.ay = rme_pkg::HALF_PI_Q13;
            a.az = 16'(round_q13(vec_angle(longint'(m.r10) * 16384,
                                           longint'(m.r20) * 16384)));
        end else if (tol > dp) begin
            a.code = rme_pkg::LOCK_POS;
            a.ax = '0;
            a.ay = -rme_pkg::HALF_PI_Q13;
            a.az = 16'(round_q13(vec_angle(-longint'(m.r10) * 16384,
                                           -longint'(m.r20) * 16384)));
        end else begin
            a.code = rme_pkg::LOCK_NONE;
            s = m.r02;
            if (s > 16384) s = 16384;
            if (s < -16384) s = -16384;
            a.ax = 16'(round_q13(-vec_angle(s * 16384,
                                            root_floor(((64'd1 << 28) - s * s) << 28))));
            a.ay = 16'(round_q13(vec_angle(longint'(m.r12) * 16384,
                                           longint'(m.r22) * 16384)));
            a.az = 16'(round_q13(vec_angle(longint'(m.r01) * 16384,
                                           longint'(m.r00) * 16384)));
        end
        return a;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch beat %0d %s: got %0d want %0d", beats_out, what, got, want);
    endtask

    // receiver: stall pattern, check each beat
    initial begin
        t_angles got;
        t_angles want;
        m_axis_tready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata};
                if (angles_due.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = angles_due.pop_front();
                    if (got.ax !== want.ax) report_mismatch("angle_x", got.ax, want.ax);
                    if (got.ay !== want.ay) report_mismatch("angle_y", got.ay, want.ay);
                    if (got.az !== want.az) report_mismatch("angle_z", got.az, want.az);
                    if (got.code !== want.code)
                        report_mismatch("lock_case", got.code, want.code);
                end
                beats_out++;
            end
            m_axis_tready <= ((cycles / 200) % 3 == 1) ? 1'b1 : ($urandom_range(0, 3) != 0);
        end
    end

    task automatic send_matrix(t_matrix m, bit has_exp, t_angles exp_a);
        t_angles p;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= m;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        p = euler_of(m);
        if (has_exp && p !== exp_a) begin
            report_mismatch("table row vs predictor", 1, 0);
        end
        angles_due = {angles_due, p};
        lock_seen[p.code]++;
        beats_in++;
    endtask

    task automatic pause_burst();
        if ($urandom_range(0, 9) < 3) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic set_tolerance(logic [14:0] v);
        s_axis_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        tol = v;
    endtask

    function automatic t_matrix rand_matrix(int mode);
        t_matrix m;
        m = 112'({$urandom, $urandom, $urandom, $urandom});
        case (mode)
            0: m.r02 = 16'($urandom_range(0, 2 * int'(tol) + 4) - int'(tol) - 2 - 16384);
            1: m.r02 = 16'($urandom_range(0, 2 * int'(tol) + 4) - int'(tol) - 2 + 16384);
            2: m.r02 = 16'($urandom_range(0, 32768) - 16384);
            default: ;
        endcase
        return m;
    endfunction

    initial begin
        t_row    rows[$];
        t_row    r;
        t_angles e;
        int      tols[5] = '{16, 0, 16384, 32767, 300};
        cycles        = 0;
        errors        = 0;
        beats_in      = 0;
        beats_out     = 0;
        tol           = 16;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: identity, locks, zero vectors, extremes
        r.has_exp = 1'b1;
        r.m = '{r22:16384, r20:0, r12:0, r10:0, r02:0, r01:0, r00:16384};
        r.exp = '{code:rme_pkg::LOCK_NONE, az:0, ay:0, ax:0};
        rows = {rows, r};
        r.m = '{r22:0, r20:0, r12:0, r10:0, r02:0, r01:0, r00:0};
        r.exp = '{code:rme_pkg::LOCK_NONE, az:0, ay:0, ax:0};
        rows = {rows, r};
        r.m = '{r22:0, r20:0, r12:0, r10:0, r02:-16384, r01:0, r00:0};
        r.exp = '{code:rme_pkg::LOCK_NEG, az:0, ay:12868, ax:0};
        rows = {rows, r};
        r.m = '{r22:0, r20:0, r12:0, r10:0, r02:16384, r01:0, r00:0};
        r.exp = '{code:rme_pkg::LOCK_POS, az:0, ay:-12868, ax:0};
        rows = {rows, r};
        r.has_exp = 1'b0;
        r.m = '{r22:-32768, r20:-32768, r12:32767, r10:32767, r02:-32768,
                r01:-32768, r00:-32768};
        rows = {rows, r};
        r.m = '{r22:32767, r20:32767, r12:-32768, r10:-32768, r02:32767,
                r01:32767, r00:32767};
        rows = {rows, r};
        r.m = '{r22:-1, r20:-5, r12:0, r10:7, r02:-16384 + 16, r01:-1, r00:0};
        rows = {rows, r};
        r.m = '{r22:-16384, r20:100, r12:1, r10:-9, r02:16384 - 15, r01:0, r00:-1};
        rows = {rows, r};
        r.m = '{r22:5, r20:0, r12:-4, r10:0, r02:11585, r01:-11585, r00:-11585};
        rows = {rows, r};
        r.m = '{r22:-16384, r20:16384, r12:0, r10:0, r02:-20000, r01:0, r00:-16384};
        rows = {rows, r};
        foreach (rows[i]) begin
            send_matrix(rows[i].m, rows[i].has_exp, rows[i].exp);
            pause_burst();
        end

        foreach (tols[t]) begin
            set_tolerance(15'(tols[t]));
            repeat (130) begin
                send_matrix(rand_matrix($urandom_range(0, 4)), 1'b0, e);
                pause_burst();
            end
        end
        s_axis_tvalid <= 1'b0;

        while (angles_due.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("%0d matrices in, %0d beats out, 5 tolerances", beats_in, beats_out);
        $display("cases: normal %0d, lock -1 %0d, lock +1 %0d",
                 lock_seen[0], lock_seen[1], lock_seen[2]);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
